// ----- rtl/mlp_relu_inference_unit_assert.svh -----
// Assertion macros for the perceptron evaluator.
// Included by the top level; needs no package.
`ifndef MLP_RELU_INFERENCE_UNIT_ASSERT_SVH
`define MLP_RELU_INFERENCE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define MLP_ASSERT(lbl, clkx, rstx, prop) \
	lbl: assert property (@(posedge clkx) disable iff (!rstx) prop) \
	else $error("assertion failed");
`define MLP_NEVER(lbl, clkx, rstx, cond) \
	lbl: assert property (@(posedge clkx) disable iff (!rstx) !(cond)) \
	else $error("forbidden condition");
`else
`define MLP_ASSERT(lbl, clkx, rstx, prop)
`define MLP_NEVER(lbl, clkx, rstx, cond)
`endif
`endif

// ----- rtl/mlp_pkg.sv -----
// Shared types and constants for the perceptron evaluator.
// No dependencies.
`default_nettype none
package mlp_pkg;
	localparam int VALUE_W        = 16;
	localparam int PROD_W         = 2 * VALUE_W;
	localparam int ACC_W          = 40;
	localparam int MUL_STEPS      = VALUE_W;
	localparam int STEP_W         = $clog2(MUL_STEPS);
	localparam int MAX_INPUTS_DEF = 16;
	localparam int MAX_HIDDEN_DEF = 32;
	localparam int PADDR_W        = 4;
	localparam int CNT_W          = 9;

	localparam logic [2:0] CMD_FEAT = 3'd0;
	localparam logic [2:0] CMD_W1   = 3'd1;
	localparam logic [2:0] CMD_B1   = 3'd2;
	localparam logic [2:0] CMD_W2   = 3'd3;
	localparam logic [2:0] CMD_B2   = 3'd4;

	localparam logic [1:0] REG_READY  = 2'd0;
	localparam logic [1:0] REG_INPUTS = 2'd1;
	localparam logic [1:0] REG_HIDDEN = 2'd2;

	typedef struct packed {
		logic [2:0]                 cmd;
		logic [8:0]                 index;
		logic signed [VALUE_W-1:0] value;
		logic                       last;
	} in_word_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] score;
		logic                       saturated;
	} out_word_t;
endpackage
`default_nettype wire

// ----- rtl/mlp_ser_mul.sv -----
// Bit-serial signed 16x16 multiplier, one multiplier bit per cycle.
// Depends on mlp_pkg.
`default_nettype none
module mlp_ser_mul import mlp_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic signed [VALUE_W-1:0] a,
	input  wire logic signed [VALUE_W-1:0] b,
	output logic                            done,
	output logic                            busy,
	output logic signed [PROD_W-1:0]        product
);
	logic signed [VALUE_W-1:0] a_q;
	logic [VALUE_W:0]          hi_q;
	logic [VALUE_W-1:0]        lo_q;
	logic [STEP_W-1:0]         cnt_q;
	logic                      run_q;
	logic                      done_q;
	logic [VALUE_W+1:0]        a_ext;
	logic [VALUE_W+1:0]        addend;
	logic [VALUE_W+1:0]        sum;

	always_comb begin
		a_ext = {{2{a_q[VALUE_W-1]}}, a_q};
		if (!lo_q[0])
			addend = '0;
		else if (cnt_q == STEP_W'(MUL_STEPS - 1))
			addend = -a_ext;
		else
			addend = a_ext;
		sum = {hi_q[VALUE_W], hi_q} + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(MUL_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (run_q) begin
			hi_q <= sum[VALUE_W+1:1];
			lo_q <= {sum[0], lo_q[VALUE_W-1:1]};
		end
	end

	assign done    = done_q;
	assign busy    = run_q;
	assign product = {hi_q[VALUE_W-1:0], lo_q};
endmodule
`default_nettype wire

// ----- rtl/mlp_relu_inference_unit.sv -----
// Two-layer ReLU perceptron evaluator with APB register port.
// Depends on mlp_pkg, mlp_ser_mul and mlp_relu_inference_unit_assert.svh.
//
// Usage: words arrive on req when start is high and busy low. A write word
// (W1, b1, W2, b2) is stored when it is taken. A feature word with an index
// below the input count runs a serial multiply-accumulate into each active
// hidden accumulator: per neuron one memory read, one multiplier load,
// 16 multiplier steps and one write, on the single bit-serial multiplier.
// A feature marked last then evaluates the output layer, per hidden neuron a
// read, a ReLU and a multiply, and raises done for exactly one cycle with the
// result on rsp; the receiver cannot stall. busy stays high for the whole
// evaluation. Registers: 0 model_ready, 1 inputs_in_use, 2 hidden_in_use at
// byte addresses 0, 4, 8; write only while idle. Reset clears the clip flag,
// model_ready and the accumulators through valid bits, and sets inputs_in_use
// to 16 and hidden_in_use to 32; weight stores are undefined until written.
`default_nettype none
`include "mlp_relu_inference_unit_assert.svh"
module mlp_relu_inference_unit import mlp_pkg::*; #(
	parameter int MAX_INPUTS = MAX_INPUTS_DEF,
	parameter int MAX_HIDDEN = MAX_HIDDEN_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire in_word_t           req,
	output logic                    done,
	output out_word_t               rsp,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	localparam int W1_DEPTH = MAX_INPUTS * MAX_HIDDEN;
	localparam int W1_AW    = (W1_DEPTH > 1) ? $clog2(W1_DEPTH) : 1;
	localparam int HID_AW   = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MAC_RD, ST_MAC_MUL, ST_FIN_RD, ST_FIN_H, ST_FIN_MUL, ST_OUT
	} state_t;

	state_t                    state_q;
	logic                      ready_q;
	logic [4:0]                inputs_q;
	logic [5:0]                hidden_q;
	logic [CNT_W-1:0]          ni;
	logic [CNT_W-1:0]          nh;
	logic                      cfg_we;
	logic                      accept;

	logic signed [VALUE_W-1:0] w1_mem [W1_DEPTH];
	logic signed [VALUE_W-1:0] b1_mem [MAX_HIDDEN];
	logic signed [VALUE_W-1:0] w2_mem [MAX_HIDDEN];
	logic signed [ACC_W-1:0]   acc_mem [MAX_HIDDEN];
	logic signed [VALUE_W-1:0] b2_q;
	logic [MAX_HIDDEN-1:0]     acc_vld_q;
	logic signed [VALUE_W-1:0] w1_rd_q;
	logic signed [VALUE_W-1:0] b1_rd_q;
	logic signed [VALUE_W-1:0] w2_rd_q;
	logic signed [ACC_W-1:0]   acc_rd_q;

	logic [W1_AW-1:0]          w1_addr_q;
	logic [HID_AW-1:0]         i_q;
	logic signed [VALUE_W-1:0] feat_q;
	logic                      last_q;
	logic signed [VALUE_W-1:0] h_q;
	logic signed [ACC_W-1:0]   y_q;
	logic                      clip_q;
	logic                      done_q;
	out_word_t                 rsp_q;

	logic                      mul_start_q;
	logic                      mul_done;
	logic                      mul_busy;
	logic signed [VALUE_W-1:0] mul_a;
	logic signed [VALUE_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;

	logic signed [ACC_W-1:0]   acc_cur;
	logic signed [ACC_W-1:0]   s_fin;
	logic [ACC_W-9:0]          s_sh;
	logic                      h_big;
	logic [ACC_W-9:0]          y_sh;
	logic                      y_hi;
	logic                      y_lo;
	logic                      last_hid;
	logic                      acc_we;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_comb begin
		if (inputs_q == '0)
			ni = CNT_W'(1);
		else if (32'(inputs_q) > MAX_INPUTS)
			ni = CNT_W'(MAX_INPUTS);
		else
			ni = CNT_W'(inputs_q);
		if (hidden_q == '0)
			nh = CNT_W'(1);
		else if (32'(hidden_q) > MAX_HIDDEN)
			nh = CNT_W'(MAX_HIDDEN);
		else
			nh = CNT_W'(hidden_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q  <= 1'b0;
			inputs_q <= 5'd16;
			hidden_q <= 6'd32;
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_READY:  ready_q  <= pwdata[0];
				REG_INPUTS: inputs_q <= pwdata[4:0];
				REG_HIDDEN: hidden_q <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_READY:  prdata = {31'd0, ready_q};
			REG_INPUTS: prdata = {27'd0, inputs_q};
			REG_HIDDEN: prdata = {26'd0, hidden_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && req.cmd == CMD_W1 && 32'(req.index) < W1_DEPTH)
			w1_mem[W1_AW'(req.index)] <= req.value;
		w1_rd_q <= w1_mem[w1_addr_q];
	end

	always_ff @(posedge clk) begin
		if (accept && req.cmd == CMD_B1 && 32'(req.index) < MAX_HIDDEN)
			b1_mem[HID_AW'(req.index)] <= req.value;
		if (accept && req.cmd == CMD_W2 && 32'(req.index) < MAX_HIDDEN)
			w2_mem[HID_AW'(req.index)] <= req.value;
		if (accept && req.cmd == CMD_B2)
			b2_q <= req.value;
		b1_rd_q <= b1_mem[i_q];
		w2_rd_q <= w2_mem[i_q];
	end

	assign acc_cur = acc_vld_q[i_q] ? acc_rd_q : '0;
	assign acc_we  = (state_q == ST_MAC_MUL) && mul_done;

	always_ff @(posedge clk) begin
		if (acc_we)
			acc_mem[i_q] <= acc_cur + {{(ACC_W-PROD_W){mul_p[PROD_W-1]}}, mul_p};
		acc_rd_q <= acc_mem[i_q];
	end

	assign mul_a = (state_q == ST_FIN_MUL) ? h_q : feat_q;
	assign mul_b = (state_q == ST_FIN_MUL) ? w2_rd_q : w1_rd_q;

	mlp_ser_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_q),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.busy    (mul_busy),
		.product (mul_p)
	);

	always_comb begin
		s_fin = acc_cur + {{(ACC_W-VALUE_W-8){b1_rd_q[VALUE_W-1]}}, b1_rd_q, 8'h00};
		s_sh  = s_fin[ACC_W-1:8];
		h_big = !s_fin[ACC_W-1] && (|s_sh[ACC_W-9:VALUE_W-1]);
		y_sh  = y_q[ACC_W-1:8];
		y_hi  = !y_sh[ACC_W-9] && (|y_sh[ACC_W-10:VALUE_W-1]);
		y_lo  = y_sh[ACC_W-9] && !(&y_sh[ACC_W-10:VALUE_W-1]);
		last_hid = (CNT_W'(i_q) == nh - CNT_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_vld_q   <= '0;
			clip_q      <= 1'b0;
			done_q      <= 1'b0;
			mul_start_q <= 1'b0;
			i_q         <= '0;
			w1_addr_q   <= '0;
			last_q      <= 1'b0;
		end else begin
			done_q      <= 1'b0;
			mul_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && req.cmd == CMD_FEAT) begin
						last_q <= req.last;
						feat_q <= req.value;
						i_q    <= '0;
						y_q    <= {{(ACC_W-VALUE_W-8){b2_q[VALUE_W-1]}}, b2_q, 8'h00};
						if (CNT_W'(req.index) < ni) begin
							w1_addr_q <= W1_AW'(req.index);
							state_q   <= ST_MAC_RD;
						end else if (req.last) begin
							state_q <= ST_FIN_RD;
						end
					end
				end
				ST_MAC_RD: begin
					mul_start_q <= 1'b1;
					state_q     <= ST_MAC_MUL;
				end
				ST_MAC_MUL: begin
					if (mul_done) begin
						acc_vld_q[i_q] <= 1'b1;
						if (last_hid) begin
							i_q     <= '0;
							state_q <= last_q ? ST_FIN_RD : ST_IDLE;
						end else begin
							i_q       <= i_q + 1'b1;
							w1_addr_q <= w1_addr_q + W1_AW'(ni);
							state_q   <= ST_MAC_RD;
						end
					end
				end
				ST_FIN_RD: state_q <= ST_FIN_H;
				ST_FIN_H: begin
					if (s_fin[ACC_W-1])
						h_q <= '0;
					else if (h_big) begin
						h_q    <= {1'b0, {(VALUE_W-1){1'b1}}};
						clip_q <= 1'b1;
					end else
						h_q <= s_sh[VALUE_W-1:0];
					mul_start_q <= 1'b1;
					state_q     <= ST_FIN_MUL;
				end
				ST_FIN_MUL: begin
					if (mul_done) begin
						y_q <= y_q + {{(ACC_W-PROD_W){mul_p[PROD_W-1]}}, mul_p};
						if (last_hid)
							state_q <= ST_OUT;
						else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_FIN_RD;
						end
					end
				end
				ST_OUT: begin
					done_q <= 1'b1;
					if (!ready_q) begin
						rsp_q.score     <= '0;
						rsp_q.saturated <= 1'b0;
					end else if (y_hi) begin
						rsp_q.score     <= {1'b0, {(VALUE_W-1){1'b1}}};
						rsp_q.saturated <= 1'b1;
					end else if (y_lo) begin
						rsp_q.score     <= {1'b1, {(VALUE_W-1){1'b0}}};
						rsp_q.saturated <= 1'b1;
					end else begin
						rsp_q.score     <= y_sh[VALUE_W-1:0];
						rsp_q.saturated <= clip_q;
					end
					acc_vld_q <= '0;
					clip_q    <= 1'b0;
					i_q       <= '0;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`MLP_ASSERT(a_done_idle, clk, arst_n, done |-> !busy)
	`MLP_ASSERT(a_sat_ready, clk, arst_n, (done && rsp.saturated) |-> ready_q)
	`MLP_NEVER(a_idle_mul, clk, arst_n, (state_q == ST_IDLE) && mul_busy)
	`MLP_ASSERT(a_done_clear, clk, arst_n, done |-> (acc_vld_q == '0) && !clip_q)
endmodule
`default_nettype wire

// ----- tb/sv/mlp_relu_inference_unit_test.sv -----
// Self-checking test of the two-layer ReLU perceptron evaluator.
// Depends on mlp_pkg and mlp_relu_inference_unit; a local predictor checks every score word.
`timescale 1ns / 100ps
module mlp_relu_inference_unit_test;
	import mlp_pkg::*;

	localparam int W1_N = MAX_INPUTS_DEF * MAX_HIDDEN_DEF;
	localparam longint LIMIT = 64'd4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_word_t req = '0;
	logic done;
	out_word_t rsp;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	mlp_relu_inference_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	logic signed [15:0] w1_mem [W1_N];
	logic signed [15:0] b1_mem [MAX_HIDDEN_DEF];
	logic signed [15:0] w2_mem [MAX_HIDDEN_DEF];
	logic signed [15:0] b2_val;
	logic signed [39:0] acc [MAX_HIDDEN_DEF];
	bit clip_flag;
	bit ready_reg;
	logic [4:0] n_in_reg;
	logic [5:0] n_hid_reg;

	out_word_t score_q[$];
	int mismatches = 0;
	int items = 0;
	longint cycles = 0;

	function automatic int eff_in();
		return (n_in_reg == 0) ? 1 : (n_in_reg > MAX_INPUTS_DEF ? MAX_INPUTS_DEF : n_in_reg);
	endfunction

	function automatic int eff_hid();
		return (n_hid_reg == 0) ? 1 : (n_hid_reg > MAX_HIDDEN_DEF ? MAX_HIDDEN_DEF : n_hid_reg);
	endfunction

	task automatic predict_score(input in_word_t w);
		int ni, nh;
		longint s, h, y;
		out_word_t r;
		ni = eff_in();
		nh = eff_hid();
		case (w.cmd)
			CMD_W1: if (w.index < W1_N) w1_mem[w.index] = w.value;
			CMD_B1: if (w.index < MAX_HIDDEN_DEF) b1_mem[w.index] = w.value;
			CMD_W2: if (w.index < MAX_HIDDEN_DEF) w2_mem[w.index] = w.value;
			CMD_B2: b2_val = w.value;
			CMD_FEAT: begin
				if (w.index < ni)
					for (int i = 0; i < nh; i++)
						acc[i] = acc[i] + 40'(longint'(w.value) * longint'(w1_mem[i * ni + w.index]));
				if (w.last) begin
					y = longint'(b2_val) * 256;
					for (int i = 0; i < nh; i++) begin
						s = longint'(acc[i]) + longint'(b1_mem[i]) * 256;
						h = s >>> 8;
						if (h < 0) h = 0;
						if (h > 32767) begin
							h = 32767;
							clip_flag = 1;
						end
						y += h * longint'(w2_mem[i]);
					end
					y = y >>> 8;
					if (y > 32767) begin
						y = 32767;
						clip_flag = 1;
					end
					if (y < -32768) begin
						y = -32768;
						clip_flag = 1;
					end
					r.score = 16'(y);
					r.saturated = clip_flag;
					if (!ready_reg) r = '0;
					score_q.push_back(r);
					for (int i = 0; i < MAX_HIDDEN_DEF; i++) acc[i] = '0;
					clip_flag = 0;
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("mlp_relu_inference_unit_test: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_word_t e;
		if (arst_n && done) begin
			if (score_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word score=%0d", rsp.score);
			end else begin
				e = score_q.pop_front();
				if (rsp.score !== e.score || rsp.saturated !== e.saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%0b got %0d/%0b",
							e.score, e.saturated, rsp.score, rsp.saturated);
				end
			end
		end
	end

	task automatic write_reg(input logic [1:0] r, input logic [31:0] d);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({r, 2'b00});
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_READY: ready_reg = d[0];
			REG_INPUTS: n_in_reg = d[4:0];
			REG_HIDDEN: n_hid_reg = d[5:0];
			default: ;
		endcase
	endtask

	// hold start until the word is taken, then idle for the requested gap
	task automatic send_word(input in_word_t w, input int gap);
		start <= 1'b1;
		req <= w;
		do @(posedge clk); while (busy);
		predict_score(w);
		items++;
		if (gap > 0) begin
			start <= 1'b0;
			req <= in_word_t'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (score_q.size() != 0) @(posedge clk);
		repeat (1500) @(posedge clk);
	endtask

	function automatic in_word_t mk(input logic [2:0] c, input int i, input int v, input bit l);
		in_word_t w;
		w.cmd = c;
		w.index = 9'(i);
		w.value = 16'(v);
		w.last = l;
		return w;
	endfunction

	// load every store entry the current sizes reach
	task automatic load_all(input int mag);
		int ni, nh;
		ni = eff_in();
		nh = eff_hid();
		for (int i = 0; i < nh; i++) begin
			for (int j = 0; j < ni; j++)
				send_word(mk(CMD_W1, i * ni + j, $urandom_range(0, 2 * mag) - mag, 0), 0);
			send_word(mk(CMD_B1, i, $urandom_range(0, 2 * mag) - mag, 0), 0);
			send_word(mk(CMD_W2, i, $urandom_range(0, 2 * mag) - mag, 0), 0);
		end
		send_word(mk(CMD_B2, $urandom_range(0, 511), $urandom_range(0, 2 * mag) - mag, 0), 0);
	endtask

	in_word_t dir_tab [$];

	initial begin
		int ni, mag, gap, burst;
		bit lst;
		in_word_t w;
		ready_reg = 0;
		n_in_reg = 5'd16;
		n_hid_reg = 6'd32;
		b2_val = 0;
		clip_flag = 0;
		for (int i = 0; i < MAX_HIDDEN_DEF; i++) begin
			acc[i] = '0;
			b1_mem[i] = 0;
			w2_mem[i] = 0;
		end
		for (int i = 0; i < W1_N; i++) w1_mem[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: small net of extreme values, out-of-range writes and positions
		write_reg(REG_INPUTS, 32'd2);
		write_reg(REG_HIDDEN, 32'd2);
		write_reg(REG_READY, 32'd0);
		dir_tab = '{
			mk(CMD_W1, 0, 32767, 1), mk(CMD_W1, 1, -32768, 0), mk(CMD_W1, 2, 32767, 0),
			mk(CMD_W1, 3, 256, 0), mk(CMD_W1, 511, -1, 0), mk(CMD_W1, 0, 32767, 0),
			mk(CMD_B1, 0, 32767, 0), mk(CMD_B1, 1, -32768, 0), mk(CMD_B1, 40, 5, 0),
			mk(CMD_W2, 0, 32767, 0), mk(CMD_W2, 1, -32768, 0), mk(CMD_W2, 200, 1, 0),
			mk(CMD_B2, 511, -32768, 1), mk(3'd5, 0, 1, 1), mk(3'd7, 511, -1, 1),
			mk(CMD_FEAT, 0, 32767, 0), mk(CMD_FEAT, 1, -32768, 1),
			mk(CMD_FEAT, 400, 1000, 1), mk(CMD_FEAT, 0, -32768, 1)
		};
		foreach (dir_tab[k]) send_word(dir_tab[k], $urandom_range(0, 3));
		settle();
		write_reg(REG_READY, 32'd1);
		foreach (dir_tab[k]) if (dir_tab[k].cmd == CMD_FEAT) send_word(dir_tab[k], 1);
		send_word(mk(CMD_FEAT, 1, 32767, 1), 0);
		settle();
		write_reg(REG_INPUTS, 32'd0);
		write_reg(REG_HIDDEN, 32'd0);
		send_word(mk(CMD_W1, 0, 100, 0), 0);
		send_word(mk(CMD_B1, 0, -3, 0), 0);
		send_word(mk(CMD_W2, 0, -700, 0), 0);
		send_word(mk(CMD_FEAT, 0, -32768, 1), 0);
		send_word(mk(CMD_FEAT, 3, 9, 1), 0);
		settle();

		// random phases over several sizes
		for (int ph = 0; items < 850; ph++) begin
			case (ph % 6)
				0: begin write_reg(REG_INPUTS, 1); write_reg(REG_HIDDEN, 1); end
				1: begin write_reg(REG_INPUTS, 31); write_reg(REG_HIDDEN, 63); end
				default: begin
					write_reg(REG_INPUTS, $urandom_range(1, 5));
					write_reg(REG_HIDDEN, $urandom_range(1, 6));
				end
			endcase
			write_reg(REG_READY, 32'($urandom_range(0, 4) != 0));
			mag = ($urandom_range(0, 2) == 0) ? 32768 : $urandom_range(16, 2000);
			load_all(mag == 32768 ? 32767 : mag);
			ni = eff_in();
			burst = 0;
			for (int k = 0; k < ((ph % 6 == 1) ? 40 : 120); k++) begin
				if (burst == 0) begin
					burst = $urandom_range(1, 12);
					gap = $urandom_range(0, 1) ? $urandom_range(1, 20) : 0;
				end
				burst--;
				case ($urandom_range(0, 19))
					0: w = in_word_t'($urandom);
					1: w = mk(3'($urandom_range(5, 7)), $urandom_range(0, 511),
						$urandom_range(0, 65535), $urandom_range(0, 1));
					2: w = mk(CMD_FEAT, $urandom_range(ni, 511), $urandom_range(0, 65535),
						$urandom_range(0, 1));
					3: w = mk(CMD_W2, $urandom_range(0, 511), $urandom_range(0, 65535), 0);
					default: begin
						lst = ($urandom_range(0, ni + 1) == 0);
						w = mk(CMD_FEAT, $urandom_range(0, ni - 1),
							(mag == 32768) ? $urandom_range(0, 65535)
								: $urandom_range(0, 2 * mag) - mag, lst);
					end
				endcase
				// drop writes to never-loaded entries
				if (w.cmd == CMD_W1 && w.index < W1_N && w.index >= ni * eff_hid())
					w.cmd = 3'd6;
				if ((w.cmd == CMD_B1 || w.cmd == CMD_W2) && w.index < MAX_HIDDEN_DEF
					&& w.index >= eff_hid())
					w.cmd = 3'd6;
				send_word(w, (burst == 0) ? gap : 0);
			end
			send_word(mk(CMD_FEAT, 0, 1, 1), 0);
			settle();
		end

		if (mismatches == 0) begin
			$display("mlp_relu_inference_unit_test: done, clean");
		end else begin
			$display("mlp_relu_inference_unit_test: done, errors");
		end
		$finish;
	end
endmodule
